[rtl/core/nfc_response_frame_deframer_assert.svh]
// Assertion macros shared by the checker of the NFC response frame deframer.
// No dependencies; included by files that assert.
`ifndef NFC_RESPONSE_FRAME_DEFRAMER_ASSERT_SVH
`define NFC_RESPONSE_FRAME_DEFRAMER_ASSERT_SVH

// Same-cycle implication, disabled while reset is high.
`define NFCRD_ASSERT_IMPLY(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, disabled while reset is high.
`define NFCRD_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

[rtl/core/nfcrd_pkg.sv]
// Types and constants of the NFC response frame deframer.
// No dependencies; imported by every module of the block.
package nfcrd_pkg;

   localparam int FRAME_BYTES = 32;
   localparam int MAX_LEN     = FRAME_BYTES - 6;

   localparam logic [7:0] PREAMBLE_BYTE  = 8'h00;
   localparam logic [7:0] START_CODE     = 8'hFF;
   localparam logic [7:0] TFI_RESPONSE   = 8'hD5;
   localparam logic [4:0] MAX_DATA_RESET = 5'd26;

   typedef enum logic [2:0] {
      STATUS_OK        = 3'd0,
      STATUS_NOT_READY = 3'd1,
      STATUS_INVALID   = 3'd2,
      STATUS_LCS_BAD   = 3'd3,
      STATUS_BAD_SIZE  = 3'd4
   } status_type;

   typedef struct packed {
      logic [7:0] rx_byte;
      logic       first;
   } req_payload_type;

   typedef struct packed {
      logic [7:0] data_byte;
      logic       has_data;
      logic       last;
      status_type status;
   } rsp_payload_type;

   typedef struct packed {
      logic            valid;
      rsp_payload_type payload;
   } step_result_type;

endpackage

[rtl/core/nfc_response_frame_deframer.sv]
// Top level of the NFC response frame deframer: input register, frame parser
// and result register. Depends on nfcrd_pkg and nfcrd_parser.
//
// The block takes the bytes of one bus read from an NFC controller, one
// transfer per byte: a status byte marked by first, then a normal information
// frame 00 00 FF LEN LCS D5 PD0..PDn. A status byte with bit 0 clear gives a
// single not-ready result. Otherwise the preamble, the length checksum, the
// length range (1 to FRAME_BYTES-6) and the TFI are checked in that order;
// any failure gives one result with the error status and last set, and the
// rest of the read is ignored. After a good header the payload is returned
// one byte per result, cut to csr max_data bytes, the final one marked last;
// an empty payload gives one OK result with no data. The data checksum,
// postamble and any padding produce nothing. A new status byte always starts
// a fresh read. The block takes one byte per clock cycle when the result side
// keeps up; a byte that yields a result waits in the input register, and its
// result is registered in the result register and offered on rsp_valid.
// max_data resets to 26 and should be written only while the block is idle.
module nfc_response_frame_deframer
   import nfcrd_pkg::*;
(
   input  logic            clock,
   input  logic            reset,
   input  logic            req_valid,
   output logic            req_ready,
   input  req_payload_type req_data,
   output logic            rsp_valid,
   input  logic            rsp_ready,
   output rsp_payload_type rsp_data,
   input  logic            csr_write_en,
   input  logic [4:0]      csr_write_data
);

   // Input register: holds one received byte until the parser consumes it.
   logic            req_valid_ff, req_valid_in;
   req_payload_type req_data_ff;

   // Result register: holds the result until the downstream side takes it.
   logic            rsp_valid_ff, rsp_valid_in;
   rsp_payload_type rsp_data_ff, rsp_data_in;

   logic [4:0]      max_data_ff;
   logic            advance;
   step_result_type result;

   // The held byte moves through the parser when the result register is
   // free or is being emptied in this cycle.
   assign advance   = req_valid_ff && (!rsp_valid_ff || rsp_ready);
   assign req_ready = !req_valid_ff || advance;

   assign req_valid_in = (req_valid && req_ready) || (req_valid_ff && !advance);
   assign rsp_valid_in = advance ? result.valid : (rsp_valid_ff && !rsp_ready);
   assign rsp_data_in  = (advance && result.valid) ? result.payload : rsp_data_ff;

   nfcrd_parser u_parser (
      .clock     (clock),
      .reset     (reset),
      .step_en   (advance),
      .step_data (req_data_ff),
      .max_data  (max_data_ff),
      .result    (result)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         req_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
         max_data_ff  <= MAX_DATA_RESET;
      end else begin
         req_valid_ff <= req_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_write_en) begin
            max_data_ff <= csr_write_data;
         end
      end
   end

   // Payload registers carry no reset; their valid flags qualify them.
   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         req_data_ff <= req_data;
      end
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

[rtl/core/nfcrd_parser.sv]
// Frame parser of the NFC response frame deframer: per-read state and the
// combinational decode of one byte. Depends on nfcrd_pkg.
module nfcrd_parser
   import nfcrd_pkg::*;
(
   input  logic            clock,
   input  logic            reset,
   input  logic            step_en,
   input  req_payload_type step_data,
   input  logic [4:0]      max_data,
   output step_result_type result
);

   typedef enum logic [2:0] {
      PS_IDLE,
      PS_PRE0,
      PS_PRE1,
      PS_START,
      PS_LEN,
      PS_LCS,
      PS_TFI,
      PS_DATA
   } parse_state_type;

   parse_state_type state_ff, state_in;
   logic [7:0]      len_ff, len_in;
   logic [4:0]      remain_ff, remain_in;
   logic [7:0]      b;
   logic [7:0]      len_m1;
   logic [7:0]      lcs_sum;
   logic [4:0]      keep;

   assign b       = step_data.rx_byte;
   assign len_m1  = len_ff - 8'd1;
   assign lcs_sum = len_ff + b;
   assign keep    = (len_m1 > {3'b000, max_data}) ? max_data : len_m1[4:0];

   always_comb begin
      state_in  = state_ff;
      len_in    = len_ff;
      remain_in = remain_ff;
      result    = '0;
      result.payload.status = STATUS_OK;
      if (step_data.first) begin
         len_in    = '0;
         remain_in = '0;
         if (!b[0]) begin
            state_in              = PS_IDLE;
            result.valid          = 1'b1;
            result.payload.last   = 1'b1;
            result.payload.status = STATUS_NOT_READY;
         end else begin
            state_in = PS_PRE0;
         end
      end else begin
         case (state_ff)
            PS_IDLE: begin
            end
            PS_PRE0, PS_PRE1: begin
               if (b != PREAMBLE_BYTE) begin
                  result.valid          = 1'b1;
                  result.payload.status = STATUS_INVALID;
               end else begin
                  state_in = (state_ff == PS_PRE0) ? PS_PRE1 : PS_START;
               end
            end
            PS_START: begin
               if (b != START_CODE) begin
                  result.valid          = 1'b1;
                  result.payload.status = STATUS_INVALID;
               end else begin
                  state_in = PS_LEN;
               end
            end
            PS_LEN: begin
               len_in   = b;
               state_in = PS_LCS;
            end
            PS_LCS: begin
               if (lcs_sum != 8'd0) begin
                  result.valid          = 1'b1;
                  result.payload.status = STATUS_LCS_BAD;
               end else if (len_ff == 8'd0 || len_ff > 8'(MAX_LEN)) begin
                  result.valid          = 1'b1;
                  result.payload.status = STATUS_BAD_SIZE;
               end else begin
                  state_in = PS_TFI;
               end
            end
            PS_TFI: begin
               if (b != TFI_RESPONSE) begin
                  result.valid          = 1'b1;
                  result.payload.status = STATUS_INVALID;
               end else if (keep == 5'd0) begin
                  // Empty payload: the read closes with a plain OK result.
                  result.valid          = 1'b1;
                  result.payload.status = STATUS_OK;
               end else begin
                  remain_in = keep;
                  state_in  = PS_DATA;
               end
            end
            PS_DATA: begin
               result.valid             = 1'b1;
               result.payload.data_byte = b;
               result.payload.has_data  = 1'b1;
               result.payload.last      = (remain_ff == 5'd1);
               remain_in                = remain_ff - 5'd1;
               if (remain_ff == 5'd1) begin
                  state_in = PS_IDLE;
               end
            end
            default: begin
               state_in = PS_IDLE;
            end
         endcase
         // Every result outside the payload ends the read.
         if (result.valid && !result.payload.has_data) begin
            result.payload.last = 1'b1;
            state_in            = PS_IDLE;
            remain_in           = '0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= PS_IDLE;
         len_ff    <= '0;
         remain_ff <= '0;
      end else if (step_en) begin
         state_ff  <= state_in;
         len_ff    <= len_in;
         remain_ff <= remain_in;
      end
   end

endmodule

[rtl/core/nfcrd_checker.sv]
// Port-level checker of the NFC response frame deframer and its bind.
// Depends on nfcrd_pkg and nfc_response_frame_deframer_assert.svh.
`include "nfc_response_frame_deframer_assert.svh"

module nfcrd_checker
   import nfcrd_pkg::*;
(
   input logic            clock,
   input logic            reset,
   input logic            req_ready,
   input logic            rsp_valid,
   input logic            rsp_ready,
   input rsp_payload_type rsp_data
);

   // A stalled result keeps its valid and its contents.
   `NFCRD_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_data), "stalled result changed")

   // A result without payload always closes the read.
   `NFCRD_ASSERT_IMPLY(a_nodata_last, clock, reset, rsp_valid && !rsp_data.has_data, rsp_data.last && rsp_data.data_byte == 8'd0, "non-data result not final")

   // Payload bytes only come from a frame that passed every check.
   `NFCRD_ASSERT_IMPLY(a_data_ok, clock, reset, rsp_valid && rsp_data.has_data, rsp_data.status == STATUS_OK, "payload with error status")

   // A draining result side never stalls the byte input.
   `NFCRD_ASSERT_IMPLY(a_flow, clock, reset, rsp_ready, req_ready, "input stalled while output drains")

endmodule

bind nfc_response_frame_deframer nfcrd_checker u_nfcrd_checker (
   .clock     (clock),
   .reset     (reset),
   .req_ready (req_ready),
   .rsp_valid (rsp_valid),
   .rsp_ready (rsp_ready),
   .rsp_data  (rsp_data)
);

[tb/testbench.sv]
// Self-checking testbench of the NFC response frame deframer.
// Depends on nfcrd_pkg and nfc_response_frame_deframer, which in turn needs nfcrd_parser.
`timescale 1ns / 100ps

module testbench;
   import nfcrd_pkg::*;

   // A byte that yields a result passes the input register and then the result
   // register, so a short pause after the last expected result leaves the block idle.
   localparam int SETTLE_CYCLES  = 8;
   localparam int WATCHDOG_LIMIT = 2000;
   localparam int RANDOM_ITEMS   = 1360;
   localparam int PHASES         = 8;
   localparam int PHASE_ITEMS    = RANDOM_ITEMS / PHASES;
   localparam int DIRECTED_ROWS  = 29;
   localparam int REPORT_LIMIT   = 10;

   // How a row of the directed table is checked. ROW_PREDICT rows go through
   // the predictor; ROW_SILENT rows must give nothing; ROW_FINAL rows must give
   // one closing result with the status typed in the row.
   typedef enum logic [1:0] {
      ROW_PREDICT,
      ROW_SILENT,
      ROW_FINAL
   } row_kind_type;

   typedef struct packed {
      logic [7:0]   rx_byte;
      logic         first;
      row_kind_type kind;
      status_type   status;
   } directed_row_type;

   logic            clock = 1'b0;
   logic            reset = 1'b1;
   logic            req_valid = 1'b0;
   logic            req_ready;
   req_payload_type req_data = '0;
   logic            rsp_valid;
   logic            rsp_ready = 1'b0;
   rsp_payload_type rsp_data;
   logic            csr_write_en = 1'b0;
   logic [4:0]      csr_write_data = '0;

   // The predictor's copy of the block state and of max_data.
   logic [5:0] frame_pos    = '0;
   logic [7:0] hdr_length   = '0;
   logic [4:0] payload_left = '0;
   logic       frame_open   = 1'b0;
   logic [4:0] keep_limit   = MAX_DATA_RESET;

   rsp_payload_type pending [$];     // results still owed by the block, oldest first
   req_payload_type read_bytes [$];  // bytes of the read being sent
   rsp_payload_type got_rsp;
   rsp_payload_type want_rsp;
   int              mismatches = 0;
   int              stall_cycles = 0;
   bit              quiet = 1'b0;    // set during the stretch with no idling

   // Directed table: an idle byte, not ready, a bad preamble, a short read, an
   // empty payload, trailing bytes, a two-byte payload at the byte extremes and
   // a length one above the largest allowed length.
   directed_row_type steps [0:DIRECTED_ROWS-1] = '{
      '{8'h00, 1'b0, ROW_SILENT,  STATUS_OK},
      '{8'hFE, 1'b1, ROW_FINAL,   STATUS_NOT_READY},
      '{8'h01, 1'b1, ROW_SILENT,  STATUS_OK},
      '{8'hFF, 1'b0, ROW_FINAL,   STATUS_INVALID},
      '{8'hFF, 1'b1, ROW_SILENT,  STATUS_OK},
      '{8'h00, 1'b0, ROW_SILENT,  STATUS_OK},
      '{8'h01, 1'b1, ROW_SILENT,  STATUS_OK},
      '{8'h00, 1'b0, ROW_SILENT,  STATUS_OK},
      '{8'h00, 1'b0, ROW_SILENT,  STATUS_OK},
      '{8'hFF, 1'b0, ROW_SILENT,  STATUS_OK},
      '{8'h01, 1'b0, ROW_SILENT,  STATUS_OK},
      '{8'hFF, 1'b0, ROW_SILENT,  STATUS_OK},
      '{8'hD5, 1'b0, ROW_FINAL,   STATUS_OK},
      '{8'hAA, 1'b0, ROW_SILENT,  STATUS_OK},
      '{8'h01, 1'b1, ROW_SILENT,  STATUS_OK},
      '{8'h00, 1'b0, ROW_SILENT,  STATUS_OK},
      '{8'h00, 1'b0, ROW_SILENT,  STATUS_OK},
      '{8'hFF, 1'b0, ROW_SILENT,  STATUS_OK},
      '{8'h03, 1'b0, ROW_SILENT,  STATUS_OK},
      '{8'hFD, 1'b0, ROW_SILENT,  STATUS_OK},
      '{8'hD5, 1'b0, ROW_SILENT,  STATUS_OK},
      '{8'hFF, 1'b0, ROW_PREDICT, STATUS_OK},
      '{8'h00, 1'b0, ROW_PREDICT, STATUS_OK},
      '{8'h01, 1'b1, ROW_SILENT,  STATUS_OK},
      '{8'h00, 1'b0, ROW_SILENT,  STATUS_OK},
      '{8'h00, 1'b0, ROW_SILENT,  STATUS_OK},
      '{8'hFF, 1'b0, ROW_SILENT,  STATUS_OK},
      '{8'h1B, 1'b0, ROW_SILENT,  STATUS_OK},
      '{8'hE5, 1'b0, ROW_FINAL,   STATUS_BAD_SIZE}
   };

   nfc_response_frame_deframer u_dut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_data       (req_data),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_data       (rsp_data),
      .csr_write_en   (csr_write_en),
      .csr_write_data (csr_write_data)
   );

   initial begin
      forever #2 clock = ~clock;
   end

   // Advances the predicted deframer by one byte. Returns 1 when the byte
   // causes a result, which is then left in res.
   function automatic bit deframe_byte(input req_payload_type item,
                                       output rsp_payload_type res);
      logic [7:0] b;
      logic [7:0] keep;
      bit         closes;
      bit         emits;
      b      = item.rx_byte;
      closes = 1'b0;
      emits  = 1'b0;
      res    = '{data_byte: 8'h00, has_data: 1'b0, last: 1'b1, status: STATUS_OK};
      if (item.first) begin
         // A status byte always opens a fresh read, abandoning any earlier one.
         frame_pos    = '0;
         hdr_length   = '0;
         payload_left = '0;
         frame_open   = 1'b1;
         if (!b[0]) begin
            closes     = 1'b1;
            res.status = STATUS_NOT_READY;
         end
      end else if (frame_open) begin
         case (frame_pos)
            6'd0, 6'd1: begin
               if (b != PREAMBLE_BYTE) begin
                  closes     = 1'b1;
                  res.status = STATUS_INVALID;
               end else begin
                  frame_pos = frame_pos + 6'd1;
               end
            end
            6'd2: begin
               if (b != START_CODE) begin
                  closes     = 1'b1;
                  res.status = STATUS_INVALID;
               end else begin
                  frame_pos = frame_pos + 6'd1;
               end
            end
            6'd3: begin
               hdr_length = b;
               frame_pos  = frame_pos + 6'd1;
            end
            6'd4: begin
               // The length checksum is checked before the length range.
               if (8'(hdr_length + b) != 8'h00) begin
                  closes     = 1'b1;
                  res.status = STATUS_LCS_BAD;
               end else if (hdr_length == 8'h00 || hdr_length > MAX_LEN) begin
                  closes     = 1'b1;
                  res.status = STATUS_BAD_SIZE;
               end else begin
                  frame_pos = frame_pos + 6'd1;
               end
            end
            6'd5: begin
               if (b != TFI_RESPONSE) begin
                  closes     = 1'b1;
                  res.status = STATUS_INVALID;
               end else begin
                  frame_pos = 6'd6;
                  keep      = hdr_length - 8'd1;
                  if (keep > {3'b000, keep_limit}) begin
                     keep = {3'b000, keep_limit};
                  end
                  payload_left = keep[4:0];
                  // An empty payload closes the read with a bare OK result.
                  closes = (payload_left == 5'd0);
               end
            end
            default: begin
               if (payload_left == 5'd0) begin
                  frame_open = 1'b0;
               end else begin
                  emits = 1'b1;
                  res   = '{data_byte: b, has_data: 1'b1, last: payload_left == 5'd1,
                            status: STATUS_OK};
                  if (payload_left == 5'd1) begin
                     frame_open = 1'b0;
                  end
                  payload_left = payload_left - 5'd1;
               end
            end
         endcase
      end
      if (closes) begin
         frame_open   = 1'b0;
         payload_left = '0;
      end
      return closes || emits;
   endfunction

   // Fills read_bytes with one random bus read. Most reads are well formed
   // frames with random payloads; the rest carry a not-ready status, a
   // corrupted header byte, a bad length or an early cut, and some are led by
   // noise bytes.
   function automatic void plan_read();
      logic [7:0]  frame [$];
      logic [7:0]  len_b;
      int unsigned pick;
      int unsigned body;
      int unsigned cut;
      int unsigned spot;
      read_bytes.delete();
      if ($urandom_range(9) == 0) begin
         repeat ($urandom_range(3, 1)) read_bytes.push_back({8'($urandom), 1'b0});
      end
      if ($urandom_range(99) < 8) begin
         read_bytes.push_back({8'($urandom) & 8'hFE, 1'b1});
         repeat ($urandom_range(5, 0)) read_bytes.push_back({8'($urandom), 1'b0});
         return;
      end
      read_bytes.push_back({8'($urandom) | 8'h01, 1'b1});
      pick = $urandom_range(99);
      if (pick < 60) begin
         len_b = 8'($urandom_range(6, 1));
      end else if (pick < 90) begin
         len_b = 8'($urandom_range(MAX_LEN, 7));
      end else if (pick < 95) begin
         len_b = 8'h00;
      end else begin
         len_b = 8'($urandom_range(255, MAX_LEN + 1));
      end
      frame = '{PREAMBLE_BYTE, PREAMBLE_BYTE, START_CODE, len_b, 8'h00 - len_b,
                TFI_RESPONSE};
      if (len_b >= 8'd1 && len_b <= MAX_LEN) begin
         body = len_b - 1;
      end else begin
         body = $urandom_range(4, 0);
      end
      repeat (body) frame.push_back(8'($urandom));
      frame.push_back(8'($urandom));
      frame.push_back(PREAMBLE_BYTE);
      if ($urandom_range(3) == 0) begin
         while (frame.size() < FRAME_BYTES) frame.push_back(8'($urandom));
      end else begin
         repeat ($urandom_range(2, 0)) frame.push_back(8'($urandom));
      end
      if ($urandom_range(99) < 15) begin
         spot        = $urandom_range(5, 0);
         frame[spot] = frame[spot] ^ 8'($urandom_range(255, 1));
      end
      if ($urandom_range(99) < 8) begin
         cut = $urandom_range(frame.size() - 1, 0);
         while (frame.size() > cut) void'(frame.pop_back());
      end
      foreach (frame[k]) read_bytes.push_back({frame[k], 1'b0});
   endfunction

   // Offers one byte, after a random gap unless in the quiet stretch, and
   // records what its transfer should cause.
   task automatic send_byte(input req_payload_type item, input row_kind_type kind,
                            input status_type fixed_status);
      rsp_payload_type res;
      bit              got;
      while (!quiet && $urandom_range(99) < 26) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= item;
      do @(posedge clock); while (!req_ready);
      got = deframe_byte(item, res);
      case (kind)
         ROW_PREDICT: begin
            if (got) begin
               pending.push_back(res);
            end
         end
         ROW_FINAL: begin
            pending.push_back('{data_byte: 8'h00, has_data: 1'b0, last: 1'b1,
                                status: fixed_status});
         end
         default: ;
      endcase
   endtask

   // Stops offering bytes and waits until every owed result has come, then
   // lets the pipeline run empty.
   task automatic drain_and_settle();
      req_valid <= 1'b0;
      while (pending.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // Stimulus: reset, the directed table, then random phases that each start
   // with a new max_data written while the block is idle.
   initial begin
      logic [4:0]  limit_plan [PHASES];
      int unsigned phase_sent;
      limit_plan = '{5'd0, 5'd31, 5'd1, 5'd26, 5'($urandom), 5'd2, 5'($urandom), 5'd31};
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      foreach (steps[i]) begin
         send_byte({steps[i].rx_byte, steps[i].first}, steps[i].kind, steps[i].status);
      end

      for (int p = 0; p < PHASES; p++) begin
         drain_and_settle();
         // The fourth phase is the long stretch in which neither side idles.
         quiet          = (p == 3);
         csr_write_en   <= 1'b1;
         csr_write_data <= limit_plan[p];
         keep_limit     = limit_plan[p];
         @(posedge clock);
         csr_write_en   <= 1'b0;
         phase_sent = 0;
         while (phase_sent < PHASE_ITEMS) begin
            plan_read();
            foreach (read_bytes[k]) begin
               send_byte(read_bytes[k], ROW_PREDICT, STATUS_OK);
               phase_sent++;
            end
         end
      end

      drain_and_settle();
      if (mismatches == 0 && pending.size() == 0) begin
         $display("testbench: done, clean");
      end else begin
         $display("testbench: done, errors");
      end
      $finish;
   end

   // The result side stalls in about a quarter of the cycles, except in the
   // quiet stretch.
   always @(posedge clock) begin
      rsp_ready <= quiet || ($urandom_range(99) >= 26);
   end

   // Each result transfer is compared field by field with the oldest owed
   // result. A result that nobody owes counts as a mismatch too.
   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         got_rsp = rsp_data;
         if (pending.size() == 0) begin
            mismatches++;
            if (mismatches <= REPORT_LIMIT) begin
               $display("unexpected result: data %02h has_data %0d last %0d status %0d",
                        got_rsp.data_byte, got_rsp.has_data, got_rsp.last, got_rsp.status);
            end
         end else begin
            want_rsp = pending.pop_front();
            if (got_rsp.data_byte !== want_rsp.data_byte
                || got_rsp.has_data !== want_rsp.has_data
                || got_rsp.last !== want_rsp.last
                || got_rsp.status !== want_rsp.status) begin
               mismatches++;
               if (mismatches <= REPORT_LIMIT) begin
                  $display("result mismatch: expected data %02h has_data %0d last %0d %0s%0d",
                           want_rsp.data_byte, want_rsp.has_data, want_rsp.last,
                           "status ", want_rsp.status);
                  $display("                 actual   data %02h has_data %0d last %0d %0s%0d",
                           got_rsp.data_byte, got_rsp.has_data, got_rsp.last,
                           "status ", got_rsp.status);
               end
            end
         end
      end
   end

   // Watchdog: a long run of cycles with no transfer on either channel means
   // the block has hung.
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         stall_cycles <= 0;
      end else if (stall_cycles >= WATCHDOG_LIMIT) begin
         $display("testbench: done, errors");
         $finish;
      end else begin
         stall_cycles <= stall_cycles + 1;
      end
   end

endmodule
